// ----- hdl/pipm_pkg.sv -----
// Shared types and constants for the PWM pulse and period meter.
package pipm_pkg;

    localparam int OUT_W     = 24;
    localparam int MIN_W     = 24;
    localparam int DISC_W    = 8;
    localparam int STALL_W   = 16;
    localparam int IDLE_W    = 16;
    localparam int DUTY_W    = 14;
    localparam int FREQ_W    = 27;
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_K_W   = 14;

    localparam logic [IDLE_W-1:0]  IDLE_MAX  = 16'hFFFF;
    localparam logic [DUTY_W-1:0]  DUTY_FULL = 14'd10000;
    localparam logic [MUL_K_W-1:0] DUTY_MUL  = 14'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ      = 3'd4;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result beat layout, lowest bit first
    localparam int OT_WIDTH_LSB  = 0;
    localparam int OT_PERIOD_LSB = 24;
    localparam int OT_DUTY_LSB   = 48;
    localparam int OT_FREQ_LSB   = 62;
    localparam int OT_MODE_BIT   = 89;
    localparam int OT_CLR_BIT    = 90;
    localparam int OT_ACC_BIT    = 91;
    localparam int OUT_TDATA_W   = 96;

    typedef struct packed {
        logic load;   // input beat taken: update channel state
        logic mul;    // form width * 10000
        logic start;  // launch both dividers
        logic push;   // load result register
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_hold;  // result register full and not being taken
    } t_sts;

endpackage

// ----- hdl/pipm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pipm_div
    import pipm_pkg::*;
#(
    parameter int NUM_W = 38,
    parameter int DEN_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, r_den, n_rem;
    logic [NUM_W-1:0] r_num;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   sh, sub;
    logic             ge;

    always_comb begin
        sh    = {r_rem, r_num[NUM_W-1]};
        ge    = (sh >= {1'b0, r_den});
        sub   = sh - {1'b0, r_den};
        n_rem = ge ? sub[DEN_W-1:0] : sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient bits shift in where numerator bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

// ----- hdl/pipm_ctrl.sv -----
// Sequencer for one meter item: update, multiply, divide, deliver.
module pipm_ctrl
    import pipm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_START;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the result register frees up
                if (!i_sts.out_hold) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

// ----- hdl/pipm_dp.sv -----
// Channel state, configuration registers, duty and frequency arithmetic.
module pipm_dp
    import pipm_pkg::*;
#(
    parameter int STAMP_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_op,
    input  logic [STAMP_BITS-1:0]  i_capture_a,
    input  logic [STAMP_BITS-1:0]  i_capture_b,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int PROD_W = STAMP_BITS + MUL_K_W;
    localparam int CMP_W  = (STAMP_BITS > MIN_W) ? STAMP_BITS : MIN_W;

    logic [MIN_W-1:0]   r_min_count;
    logic [DISC_W-1:0]  r_discard_count;
    logic [STALL_W-1:0] r_stall_limit;
    logic [STALL_W-1:0] r_timeout_ticks;
    logic [FREQ_W-1:0]  r_clock_hz;

    logic [STAMP_BITS-1:0] r_last_stamp, n_last_stamp;
    logic [IDLE_W-1:0]     r_idle, n_idle, idle_inc;
    logic [DISC_W-1:0]     r_discard_left, n_discard_left;
    logic                  r_period_mode, n_period_mode;
    logic [STAMP_BITS-1:0] r_width_store, n_width_store;
    logic [STAMP_BITS-1:0] r_period_store, n_period_store;
    logic                  r_clr, n_clr, r_acc, n_acc;
    logic [STAMP_BITS-1:0] diff;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] duty_quot;
    logic [FREQ_W-1:0] freq_quot;
    logic              duty_busy, freq_busy;
    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] freq;
    logic              both_set;
    logic              r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count     <= MIN_W'(50);
            r_discard_count <= DISC_W'(3);
            r_stall_limit   <= STALL_W'(10);
            r_timeout_ticks <= STALL_W'(20);
            r_clock_hz      <= FREQ_W'(5000000);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_MIN_COUNT:     r_min_count     <= i_cfg_wdata[MIN_W-1:0];
                CFG_DISCARD_COUNT: r_discard_count <= i_cfg_wdata[DISC_W-1:0];
                CFG_STALL_LIMIT:   r_stall_limit   <= i_cfg_wdata[STALL_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_wdata[STALL_W-1:0];
                CFG_CLOCK_HZ:      r_clock_hz      <= i_cfg_wdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    assign diff     = i_capture_a - i_capture_b;
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;

    always_comb begin
        n_last_stamp   = r_last_stamp;
        n_idle         = r_idle;
        n_discard_left = r_discard_left;
        n_period_mode  = r_period_mode;
        n_width_store  = r_width_store;
        n_period_store = r_period_store;
        n_clr          = 1'b0;
        n_acc          = 1'b0;
        if (i_op == OP_POLL) begin
            if (i_capture_a != r_last_stamp) begin
                n_last_stamp = i_capture_a;
                n_idle       = '0;
                if (r_discard_left != '0) begin
                    n_discard_left = r_discard_left - 1'b1;
                end else if (CMP_W'(diff) >= CMP_W'(r_min_count)) begin
                    n_discard_left = r_discard_count;
                    n_acc          = 1'b1;
                    n_period_mode  = !r_period_mode;
                    if (!r_period_mode) begin
                        n_width_store = diff;
                    end else begin
                        n_period_store = diff;
                    end
                end
            end else begin
                n_idle = idle_inc;
                n_clr  = (idle_inc > r_stall_limit);
            end
        end else begin
            n_idle = idle_inc;
            // timeout drops both measurements
            if (idle_inc > r_timeout_ticks) begin
                n_width_store  = '0;
                n_period_store = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp   <= '0;
            r_idle         <= '0;
            r_discard_left <= '0;
            r_period_mode  <= 1'b0;
            r_width_store  <= '0;
            r_period_store <= '0;
        end else if (i_cmd.load) begin
            r_last_stamp   <= n_last_stamp;
            r_idle         <= n_idle;
            r_discard_left <= n_discard_left;
            r_period_mode  <= n_period_mode;
            r_width_store  <= n_width_store;
            r_period_store <= n_period_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clr <= n_clr;
            r_acc <= n_acc;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_width_store) * PROD_W'(DUTY_MUL);
        end
    end

    pipm_div #(.NUM_W(PROD_W), .DEN_W(STAMP_BITS)) u_div_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (r_prod),
        .i_den   (r_period_store),
        .o_busy  (duty_busy),
        .o_quot  (duty_quot)
    );

    pipm_div #(.NUM_W(FREQ_W), .DEN_W(STAMP_BITS)) u_div_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (r_clock_hz),
        .i_den   (r_period_store),
        .o_busy  (freq_busy),
        .o_quot  (freq_quot)
    );

    always_comb begin
        both_set = (r_width_store != '0) && (r_period_store != '0);
        duty     = '0;
        freq     = '0;
        if (both_set) begin
            // floor at zero once width reaches the period
            if (duty_quot < PROD_W'(DUTY_FULL)) begin
                duty = DUTY_FULL - duty_quot[DUTY_W-1:0];
            end
            freq = freq_quot;
        end
        n_m_data = '0;
        n_m_data[OT_WIDTH_LSB  +: OUT_W]  = OUT_W'(r_width_store);
        n_m_data[OT_PERIOD_LSB +: OUT_W]  = OUT_W'(r_period_store);
        n_m_data[OT_DUTY_LSB   +: DUTY_W] = duty;
        n_m_data[OT_FREQ_LSB   +: FREQ_W] = freq;
        n_m_data[OT_MODE_BIT]             = r_period_mode;
        n_m_data[OT_CLR_BIT]              = r_clr;
        n_m_data[OT_ACC_BIT]              = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_sts.div_busy = duty_busy || freq_busy;
    assign o_sts.out_hold = r_m_valid && !i_m_tready;
    assign o_m_tvalid     = r_m_valid;
    assign o_m_tdata      = r_m_data;

endmodule

// ----- hdl/pwm_input_pulse_period_meter_top.sv -----
// Top level of the PWM input pulse width and period meter.
//
//  channel   dir  handshake               contents
//  s (item)  in   i_s_tvalid/o_s_tready   tdata, tuser = operation
//  m (result)out  o_m_tvalid/i_m_tready   tdata, 96 bits
//  cfg       in   i_cfg_wr_en             i_cfg_idx, i_cfg_wdata
//
// An item passes the update, multiply, start, divide and push states before its
// result is registered; the bit-serial divider forming width * 10000 / period
// paces it and the frequency divider runs alongside. No item is taken until the
// last is pushed. Reset is synchronous and restores the register defaults.
// The next item is taken while a result still waits in the output register;
// a result that is not taken stalls the sequencer just before delivery.
module pwm_input_pulse_period_meter_top
    import pipm_pkg::*;
#(
    parameter int STAMP_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // capture_a, capture_b, zero fill
    input  logic [((2*STAMP_BITS+7)/8)*8-1:0] i_s_tdata,
    // operation
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // pulse_width, period_count, duty_centi_pct, freq_hz, measure_period,
    // clear_status, accepted, zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    pipm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pipm_dp #(.STAMP_BITS(STAMP_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_s_tuser),
        .i_capture_a (i_s_tdata[STAMP_BITS-1:0]),
        .i_capture_b (i_s_tdata[2*STAMP_BITS-1:STAMP_BITS]),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ----- hdl/pipm_checker.sv -----
// Port-level checks on the meter, bound to its top level.
module pipm_checker
    import pipm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] freq;
    logic [OUT_W-1:0]  width, period;

    assign duty   = o_m_tdata[OT_DUTY_LSB +: DUTY_W];
    assign freq   = o_m_tdata[OT_FREQ_LSB +: FREQ_W];
    assign width  = o_m_tdata[OT_WIDTH_LSB +: OUT_W];
    assign period = o_m_tdata[OT_PERIOD_LSB +: OUT_W];

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken again while an item is at work");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> duty <= DUTY_FULL)
        else $error("duty above full scale");

    a_freq_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (freq != '0) |-> (period != '0) && (width != '0))
        else $error("frequency without both measurements");

endmodule

bind pwm_input_pulse_period_meter_top pipm_checker u_chk (.*);
